[hw/rtl/e2c_pkg.sv]
// Shared types and constants for the epoch-to-calendar converter.
// Used by e2c_ctrl, e2c_datapath and the top level; no dependencies.
`default_nettype none

package e2c_pkg;

   localparam int unsigned EPOCH_W   = 32;
   localparam int unsigned DAYS_W    = 16;
   localparam int unsigned STEP_W    = 1;
   localparam int unsigned YEAR_W    = 12;

   localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [EPOCH_W-1:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [EPOCH_W-1:0] SECS_PER_MIN  = 32'd60;

   // Each split takes two steps: quotient first, then the remainder.
   localparam logic [STEP_W-1:0] DIV_STEPS_M1  = 1'b1;

   // Reciprocals for the quotients. The dividend drops the divisor's power of two
   // first; rounding up keeps the truncated product exact over each dividend's range.
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675
   localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225
   localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15

   localparam logic [YEAR_W-1:0] BASE_YEAR     = 12'd1970;
   localparam logic [1:0]        BASE_MOD4     = 2'd2;
   localparam logic [6:0]        BASE_MOD100   = 7'd70;
   localparam logic [8:0]        BASE_MOD400   = 9'd370;
   localparam logic [4:0]        BASE_CENTURY  = 5'd20;
   localparam logic [6:0]        LAST_MOD100   = 7'd99;
   localparam logic [8:0]        LAST_MOD400   = 9'd399;

   localparam logic [3:0] MON_JAN = 4'd0;
   localparam logic [3:0] MON_FEB = 4'd1;
   localparam logic [3:0] MON_DEC = 4'd11;

   typedef struct packed {
      logic load;
      logic day_step;
      logic hour_step;
      logic min_step;
      logic year_step;
      logic month_step;
   } e2c_cmd_type;

   typedef struct packed {
      logic step_last;
      logic year_end;
      logic month_end;
   } e2c_status_type;

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         MON_JAN: len = 5'd31;
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         MON_DEC: len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/epoch_to_calendar.sv]
// Top level of the epoch-to-calendar converter: controller plus datapath.
// Depends on e2c_pkg, e2c_ctrl and e2c_datapath.
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into Gregorian
// second, minute, hour, day, month, year and century. Pulse start while busy is
// low; busy rises the next cycle and stays high through the conversion. The
// result beat appears on the rsp_ ports for one cycle, marked by rsp_valid, and
// cannot be held off, so capture it then. After the accepting edge, the day, hour
// and minute splits each take a reciprocal multiply for the quotient and then a
// multiply-subtract for the remainder. Then comes the walk of one year and then
// one month a cycle, over Y = whole years past 1970 (0..136) and M = whole months
// past January (0..11).
// A new start is taken in the same cycle as the result beat.
`default_nettype none

module epoch_to_calendar (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   output logic [5:0]       rsp_second_of_minute,
   output logic [5:0]       rsp_minute_of_hour,
   output logic [4:0]       rsp_hour_of_day,
   output logic [4:0]       rsp_day_of_month,
   output logic [3:0]       rsp_month_of_year,
   output logic [11:0]      rsp_full_year,
   output logic [4:0]       rsp_century_number
);
   import e2c_pkg::*;

   e2c_cmd_type    cmd;
   e2c_status_type status;

   e2c_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   e2c_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_epoch_seconds (req_epoch_seconds),
      .status            (status),
      .second_of_minute  (rsp_second_of_minute),
      .minute_of_hour    (rsp_minute_of_hour),
      .hour_of_day       (rsp_hour_of_day),
      .day_of_month      (rsp_day_of_month),
      .month_of_year     (rsp_month_of_year),
      .full_year         (rsp_full_year),
      .century_number    (rsp_century_number)
   );

endmodule

`default_nettype wire

[hw/rtl/e2c_ctrl.sv]
// Sequencer for the epoch-to-calendar converter: walks the division, year and month phases.
// Depends on e2c_pkg; drives e2c_datapath through command and status structs.
`default_nettype none

module e2c_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire e2c_pkg::e2c_status_type status,
   output e2c_pkg::e2c_cmd_type         cmd,
   output logic                         busy,
   output logic                         done
);
   import e2c_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DAY   = 6'b000010,
      ST_HOUR  = 6'b000100,
      ST_MIN   = 6'b001000,
      ST_YEAR  = 6'b010000,
      ST_MONTH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            cmd.day_step = 1'b1;
            if (status.step_last) state_in = ST_HOUR;
         end
         ST_HOUR: begin
            cmd.hour_step = 1'b1;
            if (status.step_last) state_in = ST_MIN;
         end
         ST_MIN: begin
            cmd.min_step = 1'b1;
            if (status.step_last) state_in = ST_YEAR;
         end
         ST_YEAR: begin
            cmd.year_step = 1'b1;
            if (status.year_end) state_in = ST_MONTH;
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            if (status.month_end) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = done_ff;

endmodule

`default_nettype wire

[hw/rtl/e2c_datapath.sv]
// Datapath of the epoch-to-calendar converter: reciprocal dividers, year and month walk.
// Depends on e2c_pkg; steered by e2c_ctrl.
`default_nettype none

module e2c_datapath (
   input  wire logic                    clock,
   input  wire e2c_pkg::e2c_cmd_type    cmd,
   input  wire logic [31:0]             req_epoch_seconds,
   output e2c_pkg::e2c_status_type      status,
   output logic [5:0]                   second_of_minute,
   output logic [5:0]                   minute_of_hour,
   output logic [4:0]                   hour_of_day,
   output logic [4:0]                   day_of_month,
   output logic [3:0]                   month_of_year,
   output logic [11:0]                  full_year,
   output logic [4:0]                   century_number
);
   import e2c_pkg::*;

   logic [EPOCH_W-1:0] rem_ff;
   logic [DAYS_W-1:0]  days_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [4:0]         hour_ff;
   logic [5:0]         minute_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [1:0]         mod4_ff;
   logic [6:0]         mod100_ff;
   logic [8:0]         mod400_ff;
   logic [4:0]         century_ff;
   logic [3:0]         mon_ff;

   logic [50:0]        day_prod;
   logic [26:0]        hour_prod;
   logic [20:0]        min_prod;
   logic [EPOCH_W-1:0] taken;
   logic               leap;
   logic [8:0]         year_len;
   logic [4:0]         mon_len;

   // drop the divisor's power of two, then multiply by the reciprocal of the odd part
   assign day_prod  = {26'd0, rem_ff[31:7]} * {25'd0, DAY_RECIP};
   assign hour_prod = {14'd0, rem_ff[16:4]} * {13'd0, HOUR_RECIP};
   assign min_prod  = {11'd0, rem_ff[11:2]} * {10'd0, MIN_RECIP};

   always_comb begin
      taken = {26'd0, minute_ff} * SECS_PER_MIN;
      if (cmd.day_step)       taken = {16'd0, days_ff} * SECS_PER_DAY;
      else if (cmd.hour_step) taken = {27'd0, hour_ff} * SECS_PER_HOUR;
   end

   assign leap     = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign year_len = leap ? 9'd366 : 9'd365;
   assign mon_len  = month_days(mon_ff, leap);

   assign status.step_last = (step_ff == '0);
   assign status.year_end  = (days_ff < {7'd0, year_len});
   assign status.month_end = (mon_ff == MON_DEC) || (days_ff < {11'd0, mon_len});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff     <= req_epoch_seconds;
         days_ff    <= '0;
         step_ff    <= DIV_STEPS_M1;
         hour_ff    <= '0;
         minute_ff  <= '0;
         year_ff    <= BASE_YEAR;
         mod4_ff    <= BASE_MOD4;
         mod100_ff  <= BASE_MOD100;
         mod400_ff  <= BASE_MOD400;
         century_ff <= BASE_CENTURY;
         mon_ff     <= MON_JAN;
      end
      if (cmd.day_step || cmd.hour_step || cmd.min_step) begin
         if (step_ff != '0) begin
            // keep the integer part of the reciprocal product as the quotient
            if (cmd.day_step)  days_ff   <= day_prod[50:35];
            if (cmd.hour_step) hour_ff   <= hour_prod[25:21];
            if (cmd.min_step)  minute_ff <= min_prod[19:14];
            step_ff <= step_ff - 1'b1;
         end else begin
            // strip the quotient from the remainder and rearm for the next split
            rem_ff  <= rem_ff - taken;
            step_ff <= DIV_STEPS_M1;
         end
      end
      if (cmd.year_step && !status.year_end) begin
         days_ff   <= days_ff - {7'd0, year_len};
         year_ff   <= year_ff + 12'd1;
         mod4_ff   <= mod4_ff + 2'd1;
         mod100_ff <= (mod100_ff == LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
         mod400_ff <= (mod400_ff == LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
         // century advances on entering a year that is one past a multiple of 100
         if (mod100_ff == 7'd0) century_ff <= century_ff + 5'd1;
      end
      if (cmd.month_step && !status.month_end) begin
         days_ff <= days_ff - {11'd0, mon_len};
         mon_ff  <= mon_ff + 4'd1;
      end
   end

   assign second_of_minute = rem_ff[5:0];
   assign minute_of_hour   = minute_ff;
   assign hour_of_day      = hour_ff;
   assign day_of_month     = days_ff[4:0] + 5'd1;
   assign month_of_year    = mon_ff + 4'd1;
   assign full_year        = year_ff;
   assign century_number   = century_ff;

endmodule

`default_nettype wire

[hw/rtl/e2c_checker.sv]
// Port-level checks for epoch_to_calendar, attached to it by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module e2c_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        rsp_valid,
   input  wire logic [4:0]  rsp_day_of_month,
   input  wire logic [3:0]  rsp_month_of_year,
   input  wire logic [11:0] rsp_full_year,
   input  wire logic [4:0]  rsp_century_number
);

   // an accepted beat keeps the block busy and yields no result the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted beat did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_of_year >= 4'd1 && rsp_month_of_year <= 4'd12 &&
                    rsp_day_of_month >= 5'd1 && rsp_full_year >= 12'd1970 &&
                    rsp_full_year <= 12'd2106)
      else $error("calendar field out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_century_number == 5'd20 && rsp_full_year <= 12'd2000) ||
                    (rsp_century_number == 5'd21 && rsp_full_year >= 12'd2001 &&
                     rsp_full_year <= 12'd2100) ||
                    (rsp_century_number == 5'd22 && rsp_full_year >= 12'd2101))
      else $error("century does not match year");

endmodule

bind epoch_to_calendar e2c_checker u_e2c_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_day_of_month   (rsp_day_of_month),
   .rsp_month_of_year  (rsp_month_of_year),
   .rsp_full_year      (rsp_full_year),
   .rsp_century_number (rsp_century_number)
);

`default_nettype wire
